>>> src/radar_gate_pulse_pair_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef RADAR_GATE_PULSE_PAIR_DEFINES_SVH
`define RADAR_GATE_PULSE_PAIR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RGPP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rgpp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RGPP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rgpp: next-cycle check failed");

`endif

>>> src/rgpp_pkg.sv
package rgpp_pkg;

	localparam int GATES       = 500;
	localparam int MAX_PULSES  = 4096;
	localparam int GATE_W      = 9;
	localparam int ADDR_W      = $clog2(GATES);
	localparam int LEN_W       = 8;
	localparam int MAG_W       = 16;
	localparam int SUM_W       = 32;
	localparam int PROD_W      = 2 * MAG_W;
	localparam int ACC_W       = 44;
	localparam int PC_W        = $clog2(MAX_PULSES) + 1;
	localparam int DVD_W       = ACC_W;
	localparam int DVS_W       = 16;
	localparam int CNT_W       = $clog2(DVD_W + 1);
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// N / GATES as (N * N_RECIP) >> N_SHIFT, exact for every 16-bit N
	localparam int N_RECIP     = 67109;
	localparam int N_SHIFT     = 25;
	localparam int N_PROD_W    = 33;

	typedef struct packed {
		logic [MAG_W-1:0] prev_v;
		logic [MAG_W-1:0] prev_h;
		logic [ACC_W-1:0] acc_v;
		logic [ACC_W-1:0] acc_h;
	} mem_word_t;

	localparam int WORD_W = $bits(mem_word_t);

	typedef enum logic [3:0] {
		S_IDLE, S_MAG, S_CHK, S_AVGV, S_AVGH,
		S_MUL, S_ACC, S_RV, S_RH, S_OUT
	} state_t;

endpackage

>>> src/rgpp_mag.sv
module rgpp_mag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] i_in,
	input  logic signed [15:0] q_in,
	output logic               done,
	output logic [rgpp_pkg::MAG_W-1:0] mag
);

	logic signed [31:0] sq_i_s1, sq_q_s1;
	logic        load_q, busy_q, done_q;
	logic [31:0] x_q;
	logic [16:0] rem_q;
	logic [15:0] r_q;
	logic [4:0]  cnt_q;
	logic [18:0] rem_n, trial;
	logic        ge;

	assign rem_n = {rem_q, x_q[31:30]};
	assign trial = {1'b0, r_q, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk) begin
		if (start) begin
			sq_i_s1 <= i_in * i_in;
			sq_q_s1 <= q_in * q_in;
		end
		if (load_q) begin
			x_q   <= 32'(sq_i_s1) + 32'(sq_q_s1);
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[29:0], 2'b00};
			rem_q <= ge ? 17'(rem_n - trial) : 17'(rem_n);
			r_q   <= {r_q[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			load_q <= start;
			done_q <= busy_q && cnt_q == 5'd1;
			if (load_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign mag  = r_q;

endmodule

>>> src/rgpp_div.sv
module rgpp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rgpp_pkg::DVD_W-1:0] dividend,
	input  logic [rgpp_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [rgpp_pkg::DVD_W-1:0] quo
);

	logic [rgpp_pkg::DVD_W-1:0] quo_q;
	logic [rgpp_pkg::DVS_W-1:0] rem_q, dvs_q;
	logic [rgpp_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q, done_q;
	logic [rgpp_pkg::DVS_W:0]   t;
	logic                       ge;

	assign t  = {rem_q, quo_q[rgpp_pkg::DVD_W-1]};
	assign ge = t >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rgpp_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rgpp_pkg::DVS_W'(t - {1'b0, dvs_q})
			            : rgpp_pkg::DVS_W'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == rgpp_pkg::CNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rgpp_pkg::CNT_W'(rgpp_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - rgpp_pkg::CNT_W'(1);
				if (cnt_q == rgpp_pkg::CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> src/rgpp_ram.sv
module rgpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/radar_gate_pulse_pair.sv
// channel | direction | handshake            | payload
// in      | to block  | in_valid / in_ready  | v_i v_q h_i h_q first_of_pulse
//         |           |                      | samples_in_pulse final_pulse
// out     | from block| out_valid / out_ready| gate_index avg_mag_v avg_mag_h
//         |           |                      | autocorr_v autocorr_h autocorr_valid last_gate
//
// One beat in flight at a time; in_ready is high only when the sequencer idles.
// A sample that does not close a gate runs two 16-step roots in parallel; a pulse start
// adds nothing, N / GATES is a constant reciprocal multiply.
// Closing a gate adds two averaging divides and the gate memory update,
// plus two more divides for the autocorrelation on a final pulse.
// Reset clears all control; the gate memory is not cleared and needs no sweep.
// A result waits in the output register; the next beat is taken meanwhile and
// stalls only if it closes a gate before that result has left.
`include "radar_gate_pulse_pair_defines.svh"

module radar_gate_pulse_pair (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] v_i,
	input  logic signed [15:0] v_q,
	input  logic signed [15:0] h_i,
	input  logic signed [15:0] h_q,
	input  logic        first_of_pulse,
	input  logic [15:0] samples_in_pulse,
	input  logic        final_pulse,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  gate_index,
	output logic [15:0] avg_mag_v,
	output logic [15:0] avg_mag_h,
	output logic [31:0] autocorr_v,
	output logic [31:0] autocorr_h,
	output logic        autocorr_valid,
	output logic        last_gate
);

	rgpp_pkg::state_t state_q, state_n;

	// control state
	logic                          active_q, final_q, out_valid_q;
	logic [rgpp_pkg::PC_W-1:0]     pc_q;
	logic [rgpp_pkg::GATE_W-1:0]   gc_q;
	logic [rgpp_pkg::LEN_W-1:0]    sig_q, base_q;
	logic [rgpp_pkg::GATE_W-1:0]   long_q;
	logic [rgpp_pkg::SUM_W-1:0]    sum_v_q, sum_h_q;

	// payload
	logic signed [15:0]            vi_q, vq_q, hi_q, hq_q;
	logic [rgpp_pkg::MAG_W-1:0]    av_q, ah_q;
	logic [rgpp_pkg::PROD_W-1:0]   pv_s1, ph_s1;
	logic [rgpp_pkg::ACC_W-1:0]    acch_q;
	logic [31:0]                   rv_q, rh_q;
	logic [rgpp_pkg::GATE_W-1:0]   gate_q;
	logic                          last_q;
	logic [8:0]                    o_gate_q;
	logic [15:0]                   o_av_q, o_ah_q;
	logic [31:0]                   o_rv_q, o_rh_q;
	logic                          o_valid_ac_q, o_last_q;

	// units
	logic                          mag_start, magv_done, magh_done;
	logic signed [15:0]            mvi, mvq, mhi, mhq;
	logic [rgpp_pkg::MAG_W-1:0]    magv, magh;
	logic                          div_start, div_done;
	logic [rgpp_pkg::DVD_W-1:0]    div_dvd, div_quo;
	logic [rgpp_pkg::DVS_W-1:0]    div_dvs;
	logic                          mem_re, mem_we;
	rgpp_pkg::mem_word_t           rd_word, wr_word;

	// derived
	logic                          accept, out_free, complete, last_n, act_n;
	logic [rgpp_pkg::LEN_W-1:0]    len;
	logic [rgpp_pkg::GATE_W-1:0]   gc_n;
	logic [rgpp_pkg::ACC_W:0]      sumv_acc, sumh_acc;
	logic [rgpp_pkg::ACC_W-1:0]    accv_n, acch_n;
	logic [31:0]                   ratio_sat;
	logic [rgpp_pkg::N_PROD_W-1:0] n_mul;
	logic [rgpp_pkg::LEN_W-1:0]    n_quo;
	logic [15:0]                   n_rem;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign len      = base_q + rgpp_pkg::LEN_W'(gc_q < long_q);
	assign complete = active_q && sig_q >= len;
	assign gc_n     = gc_q + rgpp_pkg::GATE_W'(1);
	assign last_n   = gc_n >= rgpp_pkg::GATE_W'(rgpp_pkg::GATES)
	                  || (base_q == '0 && gc_n >= long_q);

	// split the pulse into gates straight off the port: quotient and remainder by GATES
	assign n_mul = rgpp_pkg::N_PROD_W'(samples_in_pulse)
	               * rgpp_pkg::N_PROD_W'(rgpp_pkg::N_RECIP);
	assign n_quo = n_mul[rgpp_pkg::N_SHIFT +: rgpp_pkg::LEN_W];
	assign n_rem = samples_in_pulse - 16'(n_quo) * 16'(rgpp_pkg::GATES);
	assign act_n = samples_in_pulse != '0;

	// accumulate with saturation; the first pulse of a dataset clears
	assign sumv_acc = {1'b0, rd_word.acc_v} + rgpp_pkg::ACC_W'(pv_s1);
	assign sumh_acc = {1'b0, rd_word.acc_h} + rgpp_pkg::ACC_W'(ph_s1);
	assign accv_n   = pc_q <= rgpp_pkg::PC_W'(1) ? '0 :
	                  (sumv_acc[rgpp_pkg::ACC_W] ? rgpp_pkg::ACC_MAX
	                                             : sumv_acc[rgpp_pkg::ACC_W-1:0]);
	assign acch_n   = pc_q <= rgpp_pkg::PC_W'(1) ? '0 :
	                  (sumh_acc[rgpp_pkg::ACC_W] ? rgpp_pkg::ACC_MAX
	                                             : sumh_acc[rgpp_pkg::ACC_W-1:0]);
	assign ratio_sat = div_quo[rgpp_pkg::DVD_W-1:32] != '0 ? 32'hFFFF_FFFF : div_quo[31:0];

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rgpp_pkg::S_IDLE: begin
				if (in_valid) begin
					if (first_of_pulse) state_n = act_n ? rgpp_pkg::S_MAG : rgpp_pkg::S_IDLE;
					else if (active_q) state_n = rgpp_pkg::S_MAG;
				end
			end
			rgpp_pkg::S_MAG:  if (magv_done) state_n = rgpp_pkg::S_CHK;
			rgpp_pkg::S_CHK:  state_n = complete ? rgpp_pkg::S_AVGV : rgpp_pkg::S_IDLE;
			rgpp_pkg::S_AVGV: if (div_done) state_n = rgpp_pkg::S_AVGH;
			rgpp_pkg::S_AVGH: if (div_done) state_n = rgpp_pkg::S_MUL;
			rgpp_pkg::S_MUL:  state_n = rgpp_pkg::S_ACC;
			rgpp_pkg::S_ACC:  state_n = final_q ? rgpp_pkg::S_RV : rgpp_pkg::S_OUT;
			rgpp_pkg::S_RV:   if (div_done) state_n = rgpp_pkg::S_RH;
			rgpp_pkg::S_RH:   if (div_done) state_n = rgpp_pkg::S_OUT;
			rgpp_pkg::S_OUT:  if (out_free) state_n = rgpp_pkg::S_IDLE;
			default:          state_n = rgpp_pkg::S_IDLE;
		endcase
	end

	// unit control
	always_comb begin
		in_ready  = 1'b0;
		mag_start = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			rgpp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && first_of_pulse) begin
					mag_start = act_n;
				end else if (in_valid && active_q) begin
					mag_start = 1'b1;
				end
			end
			rgpp_pkg::S_CHK: begin
				if (complete) begin
					div_start = 1'b1;
					div_dvd   = rgpp_pkg::DVD_W'(sum_v_q);
					div_dvs   = rgpp_pkg::DVS_W'(len);
					mem_re    = 1'b1;
				end
			end
			rgpp_pkg::S_AVGV: begin
				div_start = div_done;
				div_dvd   = rgpp_pkg::DVD_W'(sum_h_q);
				div_dvs   = rgpp_pkg::DVS_W'(len);
			end
			rgpp_pkg::S_ACC: begin
				mem_we    = 1'b1;
				div_start = final_q;
				div_dvd   = accv_n;
				div_dvs   = rgpp_pkg::DVS_W'(pc_q);
			end
			rgpp_pkg::S_RV: begin
				div_start = div_done;
				div_dvd   = acch_q;
				div_dvs   = rgpp_pkg::DVS_W'(pc_q);
			end
			rgpp_pkg::S_AVGH, rgpp_pkg::S_MUL, rgpp_pkg::S_MAG,
			rgpp_pkg::S_RH, rgpp_pkg::S_OUT: ;
			default: ;
		endcase
	end

	// the root units see the port directly on the accepting cycle
	assign mvi = state_q == rgpp_pkg::S_IDLE ? v_i : vi_q;
	assign mvq = state_q == rgpp_pkg::S_IDLE ? v_q : vq_q;
	assign mhi = state_q == rgpp_pkg::S_IDLE ? h_i : hi_q;
	assign mhq = state_q == rgpp_pkg::S_IDLE ? h_q : hq_q;

	assign wr_word = '{prev_v: av_q, prev_h: ah_q, acc_v: accv_n, acc_h: acch_n};

	rgpp_mag u_mag_v (.clk, .arst_n, .start(mag_start), .i_in(mvi), .q_in(mvq),
		.done(magv_done), .mag(magv));
	rgpp_mag u_mag_h (.clk, .arst_n, .start(mag_start), .i_in(mhi), .q_in(mhq),
		.done(magh_done), .mag(magh));

	rgpp_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quo(div_quo));

	rgpp_ram #(.WIDTH(rgpp_pkg::WORD_W), .DEPTH(rgpp_pkg::GATES)) u_gate_mem (
		.clk,
		.re(mem_re), .raddr(gc_q[rgpp_pkg::ADDR_W-1:0]), .rdata(rd_word),
		.we(mem_we), .waddr(gc_q[rgpp_pkg::ADDR_W-1:0]), .wdata(wr_word)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rgpp_pkg::S_IDLE;
			active_q    <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			gc_q        <= '0;
			sig_q       <= '0;
			base_q      <= '0;
			long_q      <= '0;
			sum_v_q     <= '0;
			sum_h_q     <= '0;
		end else begin
			state_q <= state_n;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == rgpp_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
			// a new pulse drops whatever gate was open
			if (accept && first_of_pulse) begin
				final_q  <= final_pulse;
				pc_q     <= final_q ? rgpp_pkg::PC_W'(1) :
				            (pc_q < rgpp_pkg::PC_W'(rgpp_pkg::MAX_PULSES) ?
				             pc_q + rgpp_pkg::PC_W'(1) : pc_q);
				gc_q     <= '0;
				sig_q    <= '0;
				sum_v_q  <= '0;
				sum_h_q  <= '0;
				base_q   <= n_quo;
				long_q   <= n_rem[rgpp_pkg::GATE_W-1:0];
				active_q <= act_n;
			end
			if (state_q == rgpp_pkg::S_MAG && magv_done) begin
				sum_v_q <= sum_v_q + rgpp_pkg::SUM_W'(magv);
				sum_h_q <= sum_h_q + rgpp_pkg::SUM_W'(magh);
				sig_q   <= sig_q + rgpp_pkg::LEN_W'(1);
			end
			if (state_q == rgpp_pkg::S_ACC) begin
				gc_q     <= gc_n;
				sig_q    <= '0;
				sum_v_q  <= '0;
				sum_h_q  <= '0;
				active_q <= !last_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vi_q <= v_i;
			vq_q <= v_q;
			hi_q <= h_i;
			hq_q <= h_q;
		end
		if (state_q == rgpp_pkg::S_AVGV && div_done) av_q <= div_quo[rgpp_pkg::MAG_W-1:0];
		if (state_q == rgpp_pkg::S_AVGH && div_done) ah_q <= div_quo[rgpp_pkg::MAG_W-1:0];
		if (state_q == rgpp_pkg::S_MUL) begin
			pv_s1 <= rd_word.prev_v * av_q;
			ph_s1 <= rd_word.prev_h * ah_q;
		end
		if (state_q == rgpp_pkg::S_ACC) begin
			acch_q <= acch_n;
			gate_q <= gc_q;
			last_q <= last_n;
		end
		if (state_q == rgpp_pkg::S_RV && div_done) rv_q <= ratio_sat;
		if (state_q == rgpp_pkg::S_RH && div_done) rh_q <= ratio_sat;
		if (state_q == rgpp_pkg::S_OUT && out_free) begin
			o_gate_q     <= gate_q;
			o_av_q       <= av_q;
			o_ah_q       <= ah_q;
			o_rv_q       <= final_q ? rv_q : '0;
			o_rh_q       <= final_q ? rh_q : '0;
			o_valid_ac_q <= final_q;
			o_last_q     <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign gate_index     = o_gate_q;
	assign avg_mag_v      = o_av_q;
	assign avg_mag_h      = o_ah_q;
	assign autocorr_v     = o_rv_q;
	assign autocorr_h     = o_rh_q;
	assign autocorr_valid = o_valid_ac_q;
	assign last_gate      = o_last_q;

	// the two root units run in lockstep
	`RGPP_ASSERT_IMP(a_mag_lockstep, clk, arst_n, magv_done || magh_done, magv_done && magh_done)
	// gate counter never runs past the gate memory
	`RGPP_ASSERT_IMP(a_gate_range, clk, arst_n, mem_we, gc_q < rgpp_pkg::GATE_W'(rgpp_pkg::GATES))
	// a gate never collects more samples than its length
	`RGPP_ASSERT_IMP(a_gate_fill, clk, arst_n, state_q == rgpp_pkg::S_CHK && active_q, sig_q <= len)
	// a free output register is filled in the cycle after the result stage
	`RGPP_ASSERT_NXT(a_out_load, clk, arst_n, state_q == rgpp_pkg::S_OUT && out_free, out_valid_q)

endmodule
